FILE: design/interval_coalescer_assert.svh
// Assertion macros for the checker file of the interval coalescer.
// No dependencies; take it in with an include of the bare file name.
`ifndef INTERVAL_COALESCER_ASSERT_SVH
`define INTERVAL_COALESCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("interval coalescer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("interval coalescer assertion failed");

`endif

FILE: design/ic_pkg.sv
// Package for the interval coalescer: default widths, mode and register codes.
// No dependencies.
package ic_pkg;

    localparam int CHROM_ID_BITS_DEF = 16;
    localparam int COORD_BITS_DEF    = 31;
    localparam int VALUE_BITS        = 32;
    localparam int ADDR_BITS         = 3;
    localparam int DATA_BITS         = 32;
    localparam int MODE_BITS         = 2;

    localparam logic [MODE_BITS-1:0] MODE_UNION       = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_UNIT        = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_HIGH_PASS   = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_COMPRESSION = 2'd3;

    // register index, taken from paddr[2]
    localparam logic REG_MODE      = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

endpackage

FILE: design/interval_coalescer.sv
// Interval coalescer top level: APB registers, held interval, result buffer.
// Depends on ic_pkg.
//
// Takes a sorted stream of intervals and merges them into one held interval
// according to the mode register (union, unit, high-pass, compression); a
// flush item emits the held interval with last set. One item is accepted
// every clock cycle while item_ready is high: each item is compared against
// the held interval (chromosome equality, start versus held finish, a finish
// max) in a single pass, and any result it causes is registered, then shown.
// A result register plus one skid entry keeps items flowing while a result
// waits; item_ready drops only when both are full. No clearing pass runs
// after reset. Registers: mode at byte 0, threshold (signed Q16.16) at byte 4.
module interval_coalescer #(
    parameter int CHROM_ID_BITS = ic_pkg::CHROM_ID_BITS_DEF,
    parameter int COORD_BITS    = ic_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ic_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [ic_pkg::DATA_BITS-1:0]        pwdata,
    output logic [ic_pkg::DATA_BITS-1:0]        prdata,
    output logic                                pready,
    // items
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic                                flush,
    input  logic [CHROM_ID_BITS-1:0]            chrom_id,
    input  logic [COORD_BITS-1:0]               start_pos,
    input  logic [COORD_BITS-1:0]               finish_pos,
    input  logic signed [ic_pkg::VALUE_BITS-1:0] sample_value,
    input  logic                                value_missing,
    // results
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic [CHROM_ID_BITS-1:0]            out_chrom,
    output logic [COORD_BITS-1:0]               out_start,
    output logic [COORD_BITS-1:0]               out_finish,
    output logic signed [ic_pkg::VALUE_BITS-1:0] out_value,
    output logic                                out_missing,
    output logic                                last
);
    import ic_pkg::*;

    typedef struct packed {
        logic [CHROM_ID_BITS-1:0] chrom;
        logic [COORD_BITS-1:0]    start;
        logic [COORD_BITS-1:0]    finish;
        logic [VALUE_BITS-1:0]    value;
        logic                     missing;
        logic                     last;
    } result_t;

    // configuration registers
    logic [MODE_BITS-1:0]         mode_reg;
    logic signed [VALUE_BITS-1:0] threshold_reg;

    // held interval
    logic                         held_valid_reg, held_valid_next;
    logic [CHROM_ID_BITS-1:0]     held_chrom_reg, held_chrom_next;
    logic [COORD_BITS-1:0]        held_start_reg, held_start_next;
    logic [COORD_BITS-1:0]        held_finish_reg, held_finish_next;
    logic [VALUE_BITS-1:0]        held_value_reg, held_value_next;
    logic                         held_missing_reg, held_missing_next;

    // result register and skid entry
    logic                         main_valid_reg, main_valid_next;
    result_t                      main_reg, main_next;
    logic                         skid_valid_reg, skid_valid_next;
    result_t                      skid_reg, skid_next;

    logic    cfg_write;
    logic    accept;
    logic    pop;
    logic    comp;
    logic    drop;
    logic    same_value;
    logic    merge;
    logic    emit;
    result_t emitted;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_THRESHOLD) ? DATA_BITS'(threshold_reg)
                                                   : DATA_BITS'(mode_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_UNION;
            threshold_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_THRESHOLD)
                threshold_reg <= signed'(pwdata[VALUE_BITS-1:0]);
            else
                mode_reg <= pwdata[MODE_BITS-1:0];
        end
    end

    assign item_ready = !skid_valid_reg;
    assign accept     = item_valid && item_ready;
    assign pop        = main_valid_reg && result_ready;

    assign comp = (mode_reg == MODE_COMPRESSION);
    assign drop = ((mode_reg == MODE_UNIT) && (value_missing || sample_value == '0)) ||
                  ((mode_reg == MODE_HIGH_PASS) &&
                   (value_missing || sample_value <= threshold_reg));
    assign same_value = (value_missing && held_missing_reg) ||
                        (!value_missing && !held_missing_reg &&
                         sample_value == signed'(held_value_reg));
    assign merge = held_valid_reg && (chrom_id == held_chrom_reg) &&
                   (comp ? (start_pos == held_finish_reg && same_value)
                         : (held_finish_reg >= start_pos));
    assign emit  = held_valid_reg && (flush || (!drop && !merge));

    always_comb
    begin
        emitted.chrom   = held_chrom_reg;
        emitted.start   = held_start_reg;
        emitted.finish  = held_finish_reg;
        emitted.value   = (comp && !held_missing_reg) ? held_value_reg : '0;
        emitted.missing = comp && held_missing_reg;
        emitted.last    = flush;
    end

    // held interval update
    always_comb
    begin
        held_valid_next   = held_valid_reg;
        held_chrom_next   = held_chrom_reg;
        held_start_next   = held_start_reg;
        held_finish_next  = held_finish_reg;
        held_value_next   = held_value_reg;
        held_missing_next = held_missing_reg;
        if (accept)
        begin
            if (flush)
                held_valid_next = 1'b0;
            else if (!drop)
            begin
                if (merge)
                begin
                    if (comp || finish_pos > held_finish_reg)
                        held_finish_next = finish_pos;
                end
                else
                begin
                    held_valid_next   = 1'b1;
                    held_chrom_next   = chrom_id;
                    held_start_next   = start_pos;
                    held_finish_next  = finish_pos;
                    held_value_next   = sample_value;
                    held_missing_next = value_missing;
                end
            end
        end
    end

    // result buffer: the skid entry fills only while the result register stalls
    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept && emit)
        begin
            if (!main_valid_reg || pop)
            begin
                main_valid_next = 1'b1;
                main_next       = emitted;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = emitted;
            end
        end
        else if (pop)
            main_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_chrom_reg   <= held_chrom_next;
        held_start_reg   <= held_start_next;
        held_finish_reg  <= held_finish_next;
        held_value_reg   <= held_value_next;
        held_missing_reg <= held_missing_next;
        main_reg         <= main_next;
        skid_reg         <= skid_next;
    end

    assign result_valid = main_valid_reg;
    assign out_chrom    = main_reg.chrom;
    assign out_start    = main_reg.start;
    assign out_finish   = main_reg.finish;
    assign out_value    = signed'(main_reg.value);
    assign out_missing  = main_reg.missing;
    assign last         = main_reg.last;

endmodule

FILE: design/ic_checker.sv
// Port-level checker for the interval coalescer, bound to the top level.
// Depends on ic_pkg and interval_coalescer_assert.svh.
`include "interval_coalescer_assert.svh"

module ic_checker #(
    parameter int CHROM_ID_BITS = ic_pkg::CHROM_ID_BITS_DEF,
    parameter int COORD_BITS    = ic_pkg::COORD_BITS_DEF
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 item_ready,
    input logic                                 result_valid,
    input logic                                 result_ready,
    input logic [CHROM_ID_BITS-1:0]             out_chrom,
    input logic [COORD_BITS-1:0]                out_start,
    input logic [COORD_BITS-1:0]                out_finish,
    input logic signed [ic_pkg::VALUE_BITS-1:0] out_value,
    input logic                                 out_missing,
    input logic                                 last
);
    import ic_pkg::*;

    // a stalled result holds its payload
    `IC_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready,
        result_valid && $stable(out_chrom) && $stable(out_start) &&
        $stable(out_finish) && $stable(out_value) && $stable(out_missing) && $stable(last))

    // the skid entry is only full behind a waiting result
    `IC_ASSERT_IMPLY(a_skid_behind_result, clk, rst_n, !item_ready, result_valid)

    // item_ready falls only after a stalled result
    `IC_ASSERT_IMPLY(a_ready_fall, clk, rst_n, $fell(item_ready),
        $past(result_valid && !result_ready))

    // a missing value is always reported as zero
    `IC_ASSERT_IMPLY(a_missing_zero, clk, rst_n, result_valid && out_missing,
        out_value == '0)

endmodule

bind interval_coalescer ic_checker #(
    .CHROM_ID_BITS(CHROM_ID_BITS),
    .COORD_BITS(COORD_BITS)
) u_ic_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Testbench for interval_coalescer: directed and random (mostly sorted) streams
// of intervals, checked against a scoreboard that predicts each merged interval.
// Depends on ic_pkg and the interval_coalescer RTL.

typedef struct packed {
    logic                                   flush;
    logic [ic_pkg::CHROM_ID_BITS_DEF-1:0]   chrom;
    logic [ic_pkg::COORD_BITS_DEF-1:0]      start;
    logic [ic_pkg::COORD_BITS_DEF-1:0]      finish;
    logic signed [ic_pkg::VALUE_BITS-1:0]   value;
    logic                                   missing;
} interval_item_t;

typedef struct packed {
    logic [ic_pkg::CHROM_ID_BITS_DEF-1:0]   chrom;
    logic [ic_pkg::COORD_BITS_DEF-1:0]      start;
    logic [ic_pkg::COORD_BITS_DEF-1:0]      finish;
    logic signed [ic_pkg::VALUE_BITS-1:0]   value;
    logic                                   missing;
    logic                                   is_last;
} merged_interval_t;

class coalesce_scoreboard;
    logic [ic_pkg::MODE_BITS-1:0]           mode;
    logic signed [ic_pkg::VALUE_BITS-1:0]   threshold;
    bit                                     held_valid;
    logic [ic_pkg::CHROM_ID_BITS_DEF-1:0]   held_chrom;
    logic [ic_pkg::COORD_BITS_DEF-1:0]      held_start;
    logic [ic_pkg::COORD_BITS_DEF-1:0]      held_finish;
    logic signed [ic_pkg::VALUE_BITS-1:0]   held_value;
    logic                                   held_missing;
    merged_interval_t                       expected_intervals[$];
    int unsigned                            failures;

    function new();
        mode = ic_pkg::MODE_UNION;
        threshold = '0;
        held_valid = 1'b0;
        held_chrom = '0;
        held_start = '0;
        held_finish = '0;
        held_value = '0;
        held_missing = 1'b0;
        failures = 0;
    endfunction

    function int pending();
        return expected_intervals.size();
    endfunction

    function merged_interval_t held_interval(logic is_last);
        merged_interval_t r;
        bit comp;
        comp = (mode == ic_pkg::MODE_COMPRESSION);
        r.chrom = held_chrom;
        r.start = held_start;
        r.finish = held_finish;
        r.value = (comp && !held_missing) ? held_value : '0;
        r.missing = comp && held_missing;
        r.is_last = is_last;
        return r;
    endfunction

    // Apply one accepted item to the held interval, queue what it emits.
    function void note_item(interval_item_t it);
        bit same_value;
        if (it.flush) begin
            if (held_valid)
                expected_intervals.push_back(held_interval(1'b1));
            held_valid = 1'b0;
            return;
        end
        if (mode == ic_pkg::MODE_UNIT && (it.missing || it.value == 0))
            return;
        if (mode == ic_pkg::MODE_HIGH_PASS && (it.missing || it.value <= threshold))
            return;
        if (mode == ic_pkg::MODE_COMPRESSION) begin
            same_value = (it.missing && held_missing) ||
                         (!it.missing && !held_missing && it.value == held_value);
            if (held_valid && it.chrom == held_chrom && it.start == held_finish
                    && same_value) begin
                held_finish = it.finish;
                return;
            end
        end else if (held_valid && it.chrom == held_chrom && held_finish >= it.start) begin
            if (it.finish > held_finish)
                held_finish = it.finish;
            return;
        end
        if (held_valid)
            expected_intervals.push_back(held_interval(1'b0));
        held_valid = 1'b1;
        held_chrom = it.chrom;
        held_start = it.start;
        held_finish = it.finish;
        held_value = it.value;
        held_missing = it.missing;
    endfunction

    function void compare_field(string field, longint want, longint seen);
        if (want != seen) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, seen);
            failures++;
        end
    endfunction

    function void check_result(merged_interval_t got);
        merged_interval_t want;
        if (expected_intervals.size() == 0) begin
            $error("unexpected interval: chrom %0d start %0d finish %0d",
                   got.chrom, got.start, got.finish);
            failures++;
            return;
        end
        want = expected_intervals.pop_front();
        compare_field("out_chrom", want.chrom, got.chrom);
        compare_field("out_start", want.start, got.start);
        compare_field("out_finish", want.finish, got.finish);
        compare_field("out_value", want.value, got.value);
        compare_field("out_missing", want.missing, got.missing);
        compare_field("last", want.is_last, got.is_last);
    endfunction
endclass

module tb;
    import ic_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS = 105;
    localparam logic [ADDR_BITS-1:0] MODE_ADDR      = {REG_MODE, 2'b00};
    localparam logic [ADDR_BITS-1:0] THRESHOLD_ADDR = {REG_THRESHOLD, 2'b00};

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [ADDR_BITS-1:0]               paddr = '0;
    logic [DATA_BITS-1:0]               pwdata = '0;
    logic [DATA_BITS-1:0]               prdata;
    logic                               pready;
    logic                               item_valid = 1'b0;
    logic                               item_ready;
    logic                               flush = 1'b0;
    logic [CHROM_ID_BITS_DEF-1:0]       chrom_id = '0;
    logic [COORD_BITS_DEF-1:0]          start_pos = '0;
    logic [COORD_BITS_DEF-1:0]          finish_pos = '0;
    logic signed [VALUE_BITS-1:0]       sample_value = '0;
    logic                               value_missing = 1'b0;
    logic                               result_valid;
    logic                               result_ready = 1'b0;
    logic [CHROM_ID_BITS_DEF-1:0]       out_chrom;
    logic [COORD_BITS_DEF-1:0]          out_start;
    logic [COORD_BITS_DEF-1:0]          out_finish;
    logic signed [VALUE_BITS-1:0]       out_value;
    logic                               out_missing;
    logic                               last;

    coalesce_scoreboard sb = new();
    int unsigned        cycle_count = 0;
    bit                 steady_phase = 1'b0;
    int                 stall_left = 0;

    // stream generator state
    logic [CHROM_ID_BITS_DEF-1:0]       cur_chrom = '0;
    logic [COORD_BITS_DEF-1:0]          cur_pos = '0;
    logic signed [VALUE_BITS-1:0]       prev_value = '0;
    logic                               prev_missing = 1'b0;

    interval_coalescer dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .item_valid(item_valid), .item_ready(item_ready),
        .flush(flush), .chrom_id(chrom_id), .start_pos(start_pos),
        .finish_pos(finish_pos), .sample_value(sample_value),
        .value_missing(value_missing),
        .result_valid(result_valid), .result_ready(result_ready),
        .out_chrom(out_chrom), .out_start(out_start), .out_finish(out_finish),
        .out_value(out_value), .out_missing(out_missing), .last(last)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none in steady phases
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (steady_phase || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left > 0) begin
            result_ready <= 1'b0;
            stall_left--;
        end else begin
            result_ready <= 1'b1;
            stall_left = idle_length();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result('{out_chrom, out_start, out_finish, out_value, out_missing, last});
    end

    function automatic interval_item_t mk(logic fl, logic [15:0] ch, logic [30:0] st,
                                          logic [30:0] fi, logic [31:0] val, logic miss);
        interval_item_t it;
        it = '{fl, ch, st, fi, val, miss};
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(interval_item_t it);
        int gap;
        gap = idle_length();
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        flush <= it.flush;
        chrom_id <= it.chrom;
        start_pos <= it.start;
        finish_pos <= it.finish;
        sample_value <= it.value;
        value_missing <= it.missing;
        do
            @(posedge clk);
        while (!item_ready);
        sb.note_item(it);
        @(negedge clk);
    endtask

    // Returns after the access phase, with the bus idle again.
    task automatic apb_write(logic [ADDR_BITS-1:0] addr, logic [DATA_BITS-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == MODE_ADDR)
            sb.mode = data[MODE_BITS-1:0];
        else
            sb.threshold = data;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    // Stop sending, let all results drain, then reprogram.
    task automatic reconfigure(logic [MODE_BITS-1:0] m, logic [31:0] thr);
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        apb_write(MODE_ADDR, DATA_BITS'(m));
        apb_write(THRESHOLD_ADDR, thr);
    endtask

    // Mostly sorted intervals that overlap, touch or leave gaps; some noise.
    function automatic interval_item_t next_interval(logic signed [31:0] thr);
        interval_item_t it;
        int r;
        logic [COORD_BITS_DEF-1:0] d;
        r = $urandom_range(0, 99);
        if (r < 3)
            return mk(1'b1, 16'($urandom), 31'($urandom), 31'($urandom), $urandom,
                      1'($urandom));
        if (r < 8)
            return mk(1'b0, 16'($urandom), 31'($urandom), 31'($urandom), $urandom,
                      1'($urandom));
        if ($urandom_range(0, 19) == 0) begin
            cur_chrom = cur_chrom + CHROM_ID_BITS_DEF'($urandom_range(1, 3));
            cur_pos = COORD_BITS_DEF'($urandom_range(0, 1000));
        end
        if ($urandom_range(0, 49) == 0)
            cur_pos = 31'h7fff_ffff - COORD_BITS_DEF'($urandom_range(0, 2000));
        it.flush = 1'b0;
        it.chrom = cur_chrom;
        r = $urandom_range(0, 9);
        d = COORD_BITS_DEF'($urandom_range(1, 60));
        if (r < 4)
            it.start = cur_pos;
        else if (r < 6)
            it.start = (cur_pos > d) ? cur_pos - d : '0;
        else
            it.start = cur_pos + d;
        it.finish = it.start + COORD_BITS_DEF'($urandom_range(0, 100));
        cur_pos = it.finish;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            it.value = prev_value;
            it.missing = prev_missing;
        end else begin
            it.missing = (r < 55);
            if (r < 65)
                it.value = '0;
            else if (r < 75)
                it.value = thr + $urandom_range(0, 1);
            else
                it.value = $urandom;
        end
        prev_value = it.value;
        prev_missing = it.missing;
        return it;
    endfunction

    initial
    begin
        logic [31:0] thr;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // union: empty flush, touch, overlap, inverted, extremes
        send_item(mk(1'b1, 16'd0, 31'd0, 31'd0, 32'd0, 1'b0));
        send_item(mk(1'b0, 16'd0, 31'd0, 31'd0, 32'd0, 1'b0));
        send_item(mk(1'b0, 16'd0, 31'd0, 31'd10, 32'd0, 1'b0));
        send_item(mk(1'b0, 16'd0, 31'd10, 31'd20, 32'd7, 1'b0));
        send_item(mk(1'b0, 16'd0, 31'd15, 31'd12, 32'd7, 1'b0));
        send_item(mk(1'b0, 16'd0, 31'd21, 31'd30, 32'd7, 1'b0));
        send_item(mk(1'b0, 16'hffff, 31'h7fff_ffff, 31'h7fff_ffff, 32'h7fff_ffff, 1'b1));
        send_item(mk(1'b0, 16'hffff, 31'd0, 31'd5, 32'h8000_0000, 1'b0));
        send_item(mk(1'b1, 16'd0, 31'd0, 31'd0, 32'd0, 1'b0));

        // unit: zero and missing are dropped
        reconfigure(MODE_UNIT, 32'd0);
        send_item(mk(1'b0, 16'd1, 31'd100, 31'd200, 32'd0, 1'b0));
        send_item(mk(1'b0, 16'd1, 31'd100, 31'd200, 32'd5, 1'b1));
        send_item(mk(1'b0, 16'd1, 31'd100, 31'd200, 32'h8000_0000, 1'b0));
        send_item(mk(1'b0, 16'd1, 31'd150, 31'd300, 32'd1, 1'b0));
        send_item(mk(1'b1, 16'd0, 31'd0, 31'd0, 32'd0, 1'b0));

        // high-pass: at threshold dropped, just above kept
        reconfigure(MODE_HIGH_PASS, 32'h0001_0000);
        send_item(mk(1'b0, 16'd2, 31'd0, 31'd50, 32'h0001_0000, 1'b0));
        send_item(mk(1'b0, 16'd2, 31'd0, 31'd50, 32'h0001_0001, 1'b0));
        send_item(mk(1'b0, 16'd2, 31'd60, 31'd70, 32'h7fff_ffff, 1'b1));
        send_item(mk(1'b0, 16'd2, 31'd60, 31'd70, 32'h7fff_ffff, 1'b0));
        send_item(mk(1'b1, 16'd0, 31'd0, 31'd0, 32'd0, 1'b0));

        // compression: equal neighbors merge, one side missing does not
        reconfigure(MODE_COMPRESSION, 32'h0001_0000);
        send_item(mk(1'b0, 16'd3, 31'd0, 31'd10, 32'd5, 1'b0));
        send_item(mk(1'b0, 16'd3, 31'd10, 31'd20, 32'd5, 1'b0));
        send_item(mk(1'b0, 16'd3, 31'd20, 31'd30, 32'd6, 1'b0));
        send_item(mk(1'b0, 16'd3, 31'd30, 31'd40, 32'd6, 1'b1));
        send_item(mk(1'b0, 16'd3, 31'd40, 31'd50, 32'd9, 1'b1));
        send_item(mk(1'b0, 16'd4, 31'd50, 31'd60, 32'd9, 1'b1));
        send_item(mk(1'b1, 16'd0, 31'd0, 31'd0, 32'd0, 1'b0));

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: thr = 32'h8000_0000;
                1: thr = 32'h7fff_ffff;
                2: thr = 32'd0;
                default: thr = ($urandom_range(0, 1) == 0) ? $urandom
                                                           : $urandom_range(0, 32'h0004_0000);
            endcase
            reconfigure((p < 4) ? MODE_BITS'(3 - p % 4) : MODE_BITS'($urandom_range(0, 3)),
                        thr);
            steady_phase = (p % 5 == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_item(next_interval(thr));
        end
        steady_phase = 1'b0;
        send_item(mk(1'b1, 16'd0, 31'd0, 31'd0, 32'd0, 1'b0));
        item_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
